>>> rtl/assert_macros.svh
// Assertion macros shared by the heap keeper's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define TKSH_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define TKSH_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define TKSH_ASSERT(label, clk, rstn, prop, msg)
`define TKSH_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

>>> rtl/tksh_pkg.sv
// Types, constants and controller encodings for the top-k smallest heap keeper.
package tksh_pkg;

    localparam int unsigned TKSH_CAPACITY   = 64;
    localparam int unsigned TKSH_DIST_WIDTH = 32;
    localparam int unsigned ID_W            = 32;
    localparam int unsigned IN_DIST_W       = 32;
    localparam int unsigned K_W             = 7;
    localparam int unsigned FILL_W          = 7;
    localparam logic [K_W-1:0] K_RESET      = 7'd64;

    // Item commands
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic [ID_W-1:0]      new_id;
        logic [IN_DIST_W-1:0] new_distance;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]      max_id;
        logic [IN_DIST_W-1:0] max_distance;
        logic [FILL_W-1:0]    fill_count;
        logic                 heap_empty;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_UP_STEP,
        ST_UP_CMP,
        ST_POP_LOAD,
        ST_DOWN_STEP,
        ST_DOWN_CMP,
        ST_FINISH
    } tksh_state_t;

    // Controller to datapath
    typedef struct packed {
        logic take_in;
        logic start_append;
        logic start_replace;
        logic start_pop;
        logic rd_parent;
        logic rd_children;
        logic up_move;
        logic down_move;
        logic put_cur;
        logic load_last;
        logic emit;
    } tksh_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic op_append;
        logic op_replace;
        logic op_pop;
        logic pos_zero;
        logic leaf;
        logic parent_less;
        logic child_wins;
        logic occ_zero;
        logic out_free;
    } tksh_stat_t;

endpackage

>>> rtl/tksh_ctrl.sv
// Sequencer for insert, pop and the sift walks of the heap keeper.
`include "assert_macros.svh"

module tksh_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tksh_pkg::tksh_stat_t  stat,
    output tksh_pkg::tksh_cmd_t   cmd
);
    import tksh_pkg::*;

    tksh_state_t state_reg;
    tksh_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take_in = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.op_append) begin
                    cmd.start_append = 1'b1;
                    state_next       = ST_UP_STEP;
                end else if (stat.op_replace) begin
                    cmd.start_replace = 1'b1;
                    state_next        = ST_DOWN_STEP;
                end else if (stat.op_pop) begin
                    cmd.start_pop = 1'b1;
                    state_next    = ST_POP_LOAD;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_UP_STEP: begin
                if (stat.pos_zero) begin
                    cmd.put_cur = 1'b1;
                    state_next  = ST_FINISH;
                end else begin
                    cmd.rd_parent = 1'b1;
                    state_next    = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (stat.parent_less) begin
                    cmd.up_move = 1'b1;
                    state_next  = ST_UP_STEP;
                end else begin
                    cmd.put_cur = 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            ST_POP_LOAD: begin
                cmd.load_last = 1'b1;
                if (stat.occ_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_DOWN_STEP;
                end
            end
            ST_DOWN_STEP: begin
                if (stat.leaf) begin
                    cmd.put_cur = 1'b1;
                    state_next  = ST_FINISH;
                end else begin
                    cmd.rd_children = 1'b1;
                    state_next      = ST_DOWN_CMP;
                end
            end
            ST_DOWN_CMP: begin
                if (stat.child_wins) begin
                    cmd.down_move = 1'b1;
                    state_next    = ST_DOWN_STEP;
                end else begin
                    cmd.put_cur = 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks
    `TKSH_ASSERT(a_emit_free, aclk, aresetn, cmd.emit |-> stat.out_free, "emit while result held")
    `TKSH_ASSERT(a_one_start, aclk, aresetn, $onehot0({cmd.start_append, cmd.start_replace, cmd.start_pop}), "several starts")
    `TKSH_ASSERT(a_one_write, aclk, aresetn, $onehot0({cmd.put_cur, cmd.up_move, cmd.down_move}), "several writes")
    `TKSH_ASSERT(a_take_decide, aclk, aresetn, cmd.take_in |=> (state_reg == ST_DECIDE), "item taken without decide")

endmodule

>>> rtl/tksh_dp.sv
// Heap storage, moving item, occupancy and result register of the heap keeper.
`include "assert_macros.svh"

module tksh_dp #(
    parameter int unsigned CAPACITY   = tksh_pkg::TKSH_CAPACITY,
    parameter int unsigned DIST_WIDTH = tksh_pkg::TKSH_DIST_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tksh_pkg::in_item_t                s_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tksh_pkg::K_W-1:0]          cfg_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tksh_pkg::out_item_t               m_data,
    input  tksh_pkg::tksh_cmd_t               cmd,
    output tksh_pkg::tksh_stat_t              stat
);
    import tksh_pkg::*;

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned OW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = AW + 2;
    localparam int unsigned CW = (OW > K_W) ? OW : K_W;

    // Heap storage
    logic [ID_W-1:0]       mem_id   [CAPACITY];
    logic [DIST_WIDTH-1:0] mem_dist [CAPACITY];

    logic [K_W-1:0]        k_limit_reg;
    logic [OW-1:0]         occ_reg;
    logic [AW-1:0]         pos_reg;
    logic                  op_reg;
    logic [ID_W-1:0]       cur_id_reg;
    logic [DIST_WIDTH-1:0] cur_dist_reg;
    logic [ID_W-1:0]       root_id_reg;
    logic [DIST_WIDTH-1:0] root_dist_reg;
    logic [ID_W-1:0]       rd_a_id_reg;
    logic [DIST_WIDTH-1:0] rd_a_dist_reg;
    logic [ID_W-1:0]       rd_b_id_reg;
    logic [DIST_WIDTH-1:0] rd_b_dist_reg;
    logic                  m_valid_reg;
    out_item_t             m_data_reg;

    logic [CW-1:0]         k_ext;
    logic [CW-1:0]         eff_limit;
    logic                  below_limit;
    logic [AW-1:0]         parent_idx;
    logic [XW-1:0]         left_idx;
    logic [XW-1:0]         right_idx;
    logic [XW-1:0]         occ_ext;
    logic                  right_ok;
    logic                  left_bigger;
    logic [DIST_WIDTH-1:0] big_dist;
    logic                  right_bigger;
    logic [OW-1:0]         occ_m1;
    logic                  rd_a_en;
    logic [AW-1:0]         rd_a_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ID_W-1:0]       wr_id;
    logic [DIST_WIDTH-1:0] wr_dist;

    // Effective limit: zero acts as one, clamped to the capacity
    always_comb begin
        k_ext = CW'(k_limit_reg);
        if (k_ext == '0) begin
            eff_limit = CW'(1);
        end else if (k_ext > CW'(CAPACITY)) begin
            eff_limit = CW'(CAPACITY);
        end else begin
            eff_limit = k_ext;
        end
        below_limit = CW'(occ_reg) < eff_limit;
    end

    // Tree indices around the current position
    assign parent_idx = (pos_reg - AW'(1)) >> 1;
    assign left_idx   = XW'({pos_reg, 1'b1});
    assign right_idx  = left_idx + XW'(1);
    assign occ_ext    = XW'(occ_reg);
    assign right_ok   = right_idx < occ_ext;
    assign occ_m1     = occ_reg - OW'(1);

    // Pick the larger of the moving item and its children
    always_comb begin
        left_bigger  = cur_dist_reg < rd_a_dist_reg;
        big_dist     = left_bigger ? rd_a_dist_reg : cur_dist_reg;
        right_bigger = right_ok && (big_dist < rd_b_dist_reg);
    end

    // Status to the controller
    always_comb begin
        stat.op_append   = (op_reg == CMD_INSERT) && below_limit;
        stat.op_replace  = (op_reg == CMD_INSERT) && !below_limit && (occ_reg != '0) &&
                           (cur_dist_reg < root_dist_reg);
        stat.op_pop      = (op_reg == CMD_POP) && (occ_reg != '0);
        stat.pos_zero    = pos_reg == '0;
        stat.leaf        = left_idx >= occ_ext;
        stat.parent_less = rd_a_dist_reg < cur_dist_reg;
        stat.child_wins  = left_bigger || right_bigger;
        stat.occ_zero    = occ_reg == '0;
        stat.out_free    = !m_valid_reg || m_ready;
    end

    // Read and write port selection
    always_comb begin
        rd_a_en   = cmd.rd_parent || cmd.rd_children || cmd.start_pop;
        rd_a_addr = cmd.rd_parent ? parent_idx :
                    (cmd.rd_children ? left_idx[AW-1:0] : occ_m1[AW-1:0]);
        wr_en     = cmd.put_cur || cmd.up_move || cmd.down_move;
        wr_addr   = pos_reg;
        if (cmd.up_move) begin
            wr_id   = rd_a_id_reg;
            wr_dist = rd_a_dist_reg;
        end else if (cmd.down_move) begin
            wr_id   = right_bigger ? rd_b_id_reg : rd_a_id_reg;
            wr_dist = right_bigger ? rd_b_dist_reg : rd_a_dist_reg;
        end else begin
            wr_id   = cur_id_reg;
            wr_dist = cur_dist_reg;
        end
    end

    // Memory, registered reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_id[wr_addr]   <= wr_id;
            mem_dist[wr_addr] <= wr_dist;
        end
        if (rd_a_en) begin
            rd_a_id_reg   <= mem_id[rd_a_addr];
            rd_a_dist_reg <= mem_dist[rd_a_addr];
        end
        if (cmd.rd_children) begin
            rd_b_id_reg   <= mem_id[right_idx[AW-1:0]];
            rd_b_dist_reg <= mem_dist[right_idx[AW-1:0]];
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_limit_reg <= K_RESET;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                k_limit_reg <= cfg_data;
            end
            if (cmd.start_append) begin
                occ_reg <= occ_reg + OW'(1);
            end else if (cmd.start_pop) begin
                occ_reg <= occ_m1;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Moving item, position, root copy and result
    always_ff @(posedge aclk) begin
        if (cmd.take_in) begin
            op_reg       <= s_data.cmd;
            cur_id_reg   <= s_data.new_id;
            cur_dist_reg <= DIST_WIDTH'(s_data.new_distance);
        end else if (cmd.load_last) begin
            cur_id_reg   <= rd_a_id_reg;
            cur_dist_reg <= rd_a_dist_reg;
        end
        if (cmd.start_append) begin
            pos_reg <= occ_reg[AW-1:0];
        end else if (cmd.start_replace || cmd.start_pop) begin
            pos_reg <= '0;
        end else if (cmd.up_move) begin
            pos_reg <= parent_idx;
        end else if (cmd.down_move) begin
            pos_reg <= right_bigger ? right_idx[AW-1:0] : left_idx[AW-1:0];
        end
        if (wr_en && (wr_addr == '0)) begin
            root_id_reg   <= wr_id;
            root_dist_reg <= wr_dist;
        end
        if (cmd.emit) begin
            m_data_reg.heap_empty   <= occ_reg == '0;
            m_data_reg.fill_count   <= FILL_W'(occ_reg);
            m_data_reg.max_id       <= (occ_reg == '0) ? '0 : root_id_reg;
            m_data_reg.max_distance <= (occ_reg == '0) ? '0 : IN_DIST_W'(root_dist_reg);
        end
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Checks
    `TKSH_NEVER(a_occ_cap, aclk, aresetn, occ_reg > OW'(CAPACITY), "occupancy above capacity")
    `TKSH_ASSERT(a_wr_inside, aclk, aresetn, wr_en |-> (XW'(wr_addr) < occ_ext), "write outside heap")
    `TKSH_ASSERT(a_occ_step, aclk, aresetn, (occ_reg != $past(occ_reg)) |-> ((occ_reg == $past(occ_reg) + OW'(1)) || (occ_reg + OW'(1) == $past(occ_reg))), "occupancy jumped")

endmodule

>>> rtl/top_k_smallest_heap.sv
// Top level of the top-k smallest-distance heap keeper.
// Keeps the k_limit items with the smallest distance in a binary max-heap held in
// an on-chip memory of CAPACITY entries; every item (insert or pop) yields one
// result with the root's id and distance, the fill count and an empty flag. Items
// are handled one at a time: an item is taken and decided on, a pop first fetches
// the last item, and a sift then walks the tree level by level, reading a parent
// or both children from the memory and comparing once per level; a downward sift
// that stops above a leaf writes the moving item back after its last compare. The
// result is issued at the end. A result that m_ready holds back delays the end of
// the next item until it is taken. A finished result waits in an output register
// while the next item is taken. No clearing pass follows reset. k_limit is to be
// written over the cfg channel only while idle; the block does not enforce this;
// 0 counts as 1 and values above CAPACITY count as CAPACITY.
module top_k_smallest_heap #(
    parameter int unsigned CAPACITY   = tksh_pkg::TKSH_CAPACITY,
    parameter int unsigned DIST_WIDTH = tksh_pkg::TKSH_DIST_WIDTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  tksh_pkg::in_item_t       s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output tksh_pkg::out_item_t      m_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [tksh_pkg::K_W-1:0] cfg_data
);
    import tksh_pkg::*;

    tksh_cmd_t  cmd;
    tksh_stat_t stat;

    // Sequencer
    tksh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Storage and arithmetic
    tksh_dp #(
        .CAPACITY   (CAPACITY),
        .DIST_WIDTH (DIST_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

>>> verif/top_k_smallest_heap_tb.sv
// Self-checking testbench for the top-k smallest-distance heap keeper.
`timescale 1ns / 100ps

module top_k_smallest_heap_tb;
    import tksh_pkg::*;

    localparam int unsigned CAP         = TKSH_CAPACITY;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_WAIT  = 40;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [K_W-1:0]        cfg_data = '0;

    // Shadow heap and limit
    logic [ID_W-1:0]       shadow_ids [CAP];
    logic [IN_DIST_W-1:0]  shadow_dist [CAP];
    int unsigned           shadow_fill;
    logic [K_W-1:0]        shadow_limit;

    out_item_t             root_reports [$];
    int unsigned           error_count = 0;
    int unsigned           cycle_count = 0;
    int unsigned           stall_left = 0;
    bit                    quiet = 1'b0;

    top_k_smallest_heap u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("top_k_smallest_heap test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic int unsigned active_limit();
        if (shadow_limit < 1) return 1;
        if (shadow_limit > CAP) return CAP;
        return int'(shadow_limit);
    endfunction

    function automatic void swap_entries(int unsigned a, int unsigned b);
        logic [ID_W-1:0]      ti;
        logic [IN_DIST_W-1:0] td;
        ti = shadow_ids[a];  td = shadow_dist[a];
        shadow_ids[a] = shadow_ids[b];  shadow_dist[a] = shadow_dist[b];
        shadow_ids[b] = ti;  shadow_dist[b] = td;
    endfunction

    function automatic void sift_root_down();
        int unsigned pos;
        int unsigned big;
        pos = 0;
        while (2 * pos + 1 < shadow_fill) begin
            big = pos;
            if (shadow_dist[big] < shadow_dist[2*pos+1]) big = 2 * pos + 1;
            if (2 * pos + 2 < shadow_fill && shadow_dist[big] < shadow_dist[2*pos+2])
                big = 2 * pos + 2;
            if (big == pos) break;
            swap_entries(pos, big);
            pos = big;
        end
    endfunction

    // Apply one item to the shadow heap and queue the root report it yields
    function automatic void predict_root(input in_item_t it);
        int unsigned pos;
        out_item_t   r;
        if (it.cmd == CMD_INSERT) begin
            if (shadow_fill < active_limit()) begin
                pos = shadow_fill;
                shadow_ids[pos] = it.new_id;
                shadow_dist[pos] = it.new_distance;
                shadow_fill++;
                while (pos > 0 && shadow_dist[(pos-1)/2] < shadow_dist[pos]) begin
                    swap_entries((pos - 1) / 2, pos);
                    pos = (pos - 1) / 2;
                end
            end else if (shadow_fill > 0 && it.new_distance < shadow_dist[0]) begin
                shadow_ids[0] = it.new_id;
                shadow_dist[0] = it.new_distance;
                sift_root_down();
            end
        end else if (shadow_fill > 0) begin
            shadow_fill--;
            shadow_ids[0] = shadow_ids[shadow_fill];
            shadow_dist[0] = shadow_dist[shadow_fill];
            sift_root_down();
        end
        r.fill_count = shadow_fill[FILL_W-1:0];
        r.heap_empty = (shadow_fill == 0);
        r.max_id = r.heap_empty ? '0 : shadow_ids[0];
        r.max_distance = r.heap_empty ? '0 : shadow_dist[0];
        root_reports = {root_reports, r};
    endfunction

    // Send one item, with optional idle burst before it; valid is left high
    // after the accept and dropped by the next idle burst or drain
    task automatic send_item(input logic cmd, input logic [31:0] id,
                             input logic [31:0] distance);
        in_item_t it;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        it.cmd = cmd;  it.new_id = id;  it.new_distance = distance;
        s_data  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_root(it);
        @(negedge aclk);
    endtask

    // Result side: random stall bursts on m_ready
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (m_ready && !quiet && $urandom_range(0, 3) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare at each accepted result
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (root_reports.size() == 0) begin
                report_mismatch("unexpected result", m_data.max_id, 32'd0);
            end else begin
                want = root_reports.pop_front();
                if (m_data.max_id !== want.max_id)
                    report_mismatch("max_id", m_data.max_id, want.max_id);
                if (m_data.max_distance !== want.max_distance)
                    report_mismatch("max_distance", m_data.max_distance,
                                    want.max_distance);
                if (m_data.fill_count !== want.fill_count)
                    report_mismatch("fill_count", 32'(m_data.fill_count),
                                    32'(want.fill_count));
                if (m_data.heap_empty !== want.heap_empty)
                    report_mismatch("heap_empty", 32'(m_data.heap_empty),
                                    32'(want.heap_empty));
            end
        end
    end

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (root_reports.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    // Write k_limit while the block is idle
    task automatic write_limit(input logic [K_W-1:0] k);
        wait_drained();
        cfg_data  <= k;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        shadow_limit = k;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_heap();
        while (shadow_fill > 0) send_item(CMD_POP, $urandom, $urandom);
    endtask

    // Directed: empty pop, extremes, ties, limit clamps and lowering
    task automatic test_directed();
        send_item(CMD_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_INSERT, 32'h0, 32'h0);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_INSERT, 32'hA5A5_5A5A, 32'h8000_0000);
        send_item(CMD_INSERT, 32'h1234_5678, 32'h8000_0000);
        send_item(CMD_POP, 32'h0, 32'h0);
        drain_heap();
        send_item(CMD_POP, 32'h0, 32'h0);
        // zero limit behaves as one; tie at root is dropped
        write_limit(7'd0);
        send_item(CMD_INSERT, 32'd1, 32'd500);
        send_item(CMD_INSERT, 32'd2, 32'd500);
        send_item(CMD_INSERT, 32'd3, 32'd499);
        send_item(CMD_INSERT, 32'd4, 32'hFFFF_FFFF);
        // lower below occupancy: heap counts as full
        write_limit(7'd4);
        for (int i = 0; i < 4; i++) send_item(CMD_INSERT, 32'd10 + i, 32'd100 * i);
        write_limit(7'd2);
        send_item(CMD_INSERT, 32'd20, 32'd50);
        send_item(CMD_INSERT, 32'd21, 32'd1000);
        drain_heap();
        // above capacity clamps
        write_limit(7'd127);
    endtask

    // Fill to capacity at the largest limit, then overflow
    task automatic test_full_capacity();
        for (int i = 0; i < CAP + 8; i++) send_item(CMD_INSERT, $urandom, $urandom);
        drain_heap();
    endtask

    // Random phases over several limits
    task automatic test_random(input int unsigned items);
        logic [K_W-1:0] lim;
        int unsigned    mode;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: lim = 7'd1;
                1: lim = 7'd64;
                2: lim = 7'd127;
                default: lim = K_W'($urandom_range(0, 127));
            endcase
            write_limit(lim);
            mode = $urandom_range(0, 2);
            for (int i = 0; i < items / 8; i++) begin
                if (p == 7 && i > items / 16) quiet = 1'b1;
                if (mode == 0)
                    send_item(($urandom_range(0, 3) == 0) ? CMD_POP : CMD_INSERT,
                              $urandom, $urandom);
                else if (mode == 1)
                    send_item(($urandom_range(0, 3) == 0) ? CMD_POP : CMD_INSERT,
                              $urandom, $urandom_range(0, 15));
                else
                    send_item(1'($urandom_range(0, 1)), $urandom,
                              {2'($urandom_range(0, 3)), 30'h0} |
                              32'($urandom_range(0, 7)));
            end
        end
        drain_heap();
    endtask

    initial begin
        shadow_fill  = 0;
        shadow_limit = K_RESET;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_full_capacity();
        test_random(900);
        wait_drained();
        if (error_count == 0)
            $display("top_k_smallest_heap test passed");
        else
            $display("top_k_smallest_heap test failed");
        $finish;
    end

endmodule
